FILE: src/three_level_page_map_assert.svh
// Assertion shorthands for the page map checker.
// Both expect signals named clk and rst in the scope where they are used.
`ifndef THREE_LEVEL_PAGE_MAP_ASSERT_SVH
`define THREE_LEVEL_PAGE_MAP_ASSERT_SVH

// Check a consequence in the same cycle as its trigger.
`define TLPM_CHECK_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check a consequence in the cycle after its trigger.
`define TLPM_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/tlpm_pkg.sv
`default_nettype none

package tlpm_pkg;

  // Map geometry and node pools
  localparam int ROOT_BITS    = 4;
  localparam int BRANCH_BITS  = 6;
  localparam int LEAF_BITS    = 6;
  localparam int BRANCH_NODES = 16;
  localparam int LEAF_NODES   = 64;
  localparam int HANDLE_BITS  = 32;

  // Transaction field widths
  localparam int CMD_W     = 2;
  localparam int PAGE_ID_W = 16;
  localparam int SPAN_W    = 32;
  localparam int COUNT_W   = 16;
  localparam int STATUS_W  = 2;

  // Derived sizes
  localparam int ROOT_SIZE   = 1 << ROOT_BITS;
  localparam int BRANCH_SIZE = 1 << BRANCH_BITS;
  localparam int LEAF_SIZE   = 1 << LEAF_BITS;
  localparam int PAGE_BITS   = ROOT_BITS + BRANCH_BITS + LEAF_BITS;
  localparam int GROUP_BITS  = ROOT_BITS + BRANCH_BITS;
  localparam int BN_W        = (BRANCH_NODES > 1) ? $clog2(BRANCH_NODES) : 1;
  localparam int LN_W        = (LEAF_NODES > 1) ? $clog2(LEAF_NODES) : 1;
  localparam int BUSED_W     = $clog2(BRANCH_NODES + 1);
  localparam int LUSED_W     = $clog2(LEAF_NODES + 1);
  localparam int BDEPTH      = BRANCH_NODES * BRANCH_SIZE;
  localparam int LDEPTH      = LEAF_NODES * LEAF_SIZE;
  localparam int BA_W        = $clog2(BDEPTH);
  localparam int LA_W        = $clog2(LDEPTH);
  localparam int BENTRY_W    = LN_W + 1;
  localparam int CLR_W       = (BRANCH_BITS > LEAF_BITS) ? BRANCH_BITS : LEAF_BITS;
  localparam int SUM_W       = ((PAGE_BITS > COUNT_W) ? PAGE_BITS : COUNT_W) + 1;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
  localparam logic [CMD_W-1:0] CMD_STORE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ENSURE = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISSING   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ROOT,
    S_BCHK,
    S_LWAIT,
    S_ENS_ROOT,
    S_CLR_BRANCH,
    S_ENS_BRD,
    S_ENS_BCHK,
    S_CLR_LEAF,
    S_ENS_NEXT,
    S_DONE
  } tlpm_state_t;

endpackage

`default_nettype wire

FILE: src/tlpm_req_if.sv
`default_nettype none

interface tlpm_req_if import tlpm_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CMD_W-1:0]     cmd;
  logic [PAGE_ID_W-1:0] page_id;
  logic [SPAN_W-1:0]    span_handle;
  logic [COUNT_W-1:0]   page_count;

  modport source (output valid, cmd, page_id, span_handle, page_count, input ready);
  modport sink   (input valid, cmd, page_id, span_handle, page_count, output ready);
endinterface

`default_nettype wire

FILE: src/tlpm_rsp_if.sv
`default_nettype none

interface tlpm_rsp_if import tlpm_pkg::*;;
  logic                valid;
  logic                ready;
  logic [SPAN_W-1:0]   found_handle;
  logic [STATUS_W-1:0] status;

  modport source (output valid, found_handle, status, input ready);
  modport sink   (input valid, found_handle, status, output ready);
endinterface

`default_nettype wire

FILE: src/three_level_page_map.sv
// Three-level page map: page number -> span handle, radix walk root/branch/leaf.
// Channels: req carries cmd, page_id, span_handle and page_count; rsp returns
// found_handle and status, exactly one response per request, in order.
// One request is worked at a time; req.ready is high while the walker is idle,
// also while an earlier response still sits in the output register.
// Lookup walks S_ROOT, S_BCHK and S_LWAIT, store walks S_ROOT and S_BCHK, both
// leaving early for S_DONE when a node is absent; an unused command or empty
// ensure goes straight to S_DONE, which returns to idle for the next request.
// Ensure walks each leaf group through S_ENS_ROOT, S_ENS_BRD, S_ENS_BCHK and
// S_ENS_NEXT; every new branch or leaf node is first cleared one word per
// cycle through the single port of its memory.
// Lookup and store are bound by the chain root flops -> branch RAM read ->
// leaf RAM access, each RAM read being registered.
// Reset (synchronous, active high) marks all root entries absent and empties
// both node pools; branch and leaf RAMs need no clearing pass since only
// cleared nodes are ever read.
// A stalled rsp holds its transaction; a finished request waits for the
// output register to free up before the walker returns to idle.
`default_nettype none

module three_level_page_map import tlpm_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  tlpm_req_if.sink   req,
  tlpm_rsp_if.source rsp
);

  tlpm_state_t state, state_next;

  // Transaction registers
  logic [CMD_W-1:0]      cmd_q;
  logic [LEAF_BITS-1:0]  lidx_q;
  logic [SPAN_W-1:0]     handle_q;
  logic [GROUP_BITS-1:0] grp, grp_last;

  // Root table and pools
  logic                  root_valid [ROOT_SIZE];
  logic [BN_W-1:0]       root_node  [ROOT_SIZE];
  logic [BUSED_W-1:0]    bused;
  logic [LUSED_W-1:0]    lused;
  logic [LN_W-1:0]       alloc_leaf;
  logic [CLR_W-1:0]      clr;

  // Result and output registers
  logic [SPAN_W-1:0]     res_handle, res_handle_next;
  logic [STATUS_W-1:0]   res_status, res_status_next;
  logic                  res_set;
  logic                  rsp_vld;
  logic [SPAN_W-1:0]     rsp_handle;
  logic [STATUS_W-1:0]   rsp_status;

  // Memory ports
  logic                  b_we, l_we;
  logic [BA_W-1:0]       b_addr;
  logic [LA_W-1:0]       l_addr;
  logic [BENTRY_W-1:0]   b_wdata, b_rdata;
  logic [HANDLE_BITS-1:0] l_wdata, l_rdata;

  // Control strobes
  logic                  accept, root_alloc, leaf_alloc, clr_step, grp_step, rsp_load;

  // Derived walk values
  logic [ROOT_BITS-1:0]  r_idx;
  logic                  root_hit;
  logic [BN_W-1:0]       root_nd;
  logic                  b_hit;
  logic [LN_W-1:0]       b_node;
  logic                  is_store;
  logic                  bpool_empty, lpool_empty;
  logic                  clr_branch_last, clr_leaf_last;
  logic [BA_W-1:0]       b_walk_addr;

  // Range end for ensure, from the incoming transaction
  logic [PAGE_BITS-1:0]  first_page, range_end;
  logic [SUM_W-1:0]      range_sum, page_max;

  tlpm_ram #(.WIDTH(BENTRY_W), .DEPTH(BDEPTH)) u_branch_ram (
    .clk   (clk),
    .we    (b_we),
    .addr  (b_addr),
    .wdata (b_wdata),
    .rdata (b_rdata)
  );

  tlpm_ram #(.WIDTH(HANDLE_BITS), .DEPTH(LDEPTH)) u_leaf_ram (
    .clk   (clk),
    .we    (l_we),
    .addr  (l_addr),
    .wdata (l_wdata),
    .rdata (l_rdata)
  );

  assign accept    = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);

  assign rsp.valid        = rsp_vld;
  assign rsp.found_handle = rsp_handle;
  assign rsp.status       = rsp_status;

  // Decode the current walk position
  assign r_idx           = grp[GROUP_BITS-1 -: ROOT_BITS];
  assign root_hit        = root_valid[r_idx];
  assign root_nd         = root_node[r_idx];
  assign b_hit           = b_rdata[LN_W];
  assign b_node          = b_rdata[LN_W-1:0];
  assign is_store        = (cmd_q == CMD_STORE);
  assign bpool_empty     = (bused == BUSED_W'(BRANCH_NODES));
  assign lpool_empty     = (lused == LUSED_W'(LEAF_NODES));
  assign clr_branch_last = (clr == CLR_W'(BRANCH_SIZE - 1));
  assign clr_leaf_last   = (clr == CLR_W'(LEAF_SIZE - 1));
  assign b_walk_addr     = BA_W'({root_nd, grp[BRANCH_BITS-1:0]});

  // Clip the ensure range at the top of the map
  assign first_page = PAGE_BITS'(req.page_id);
  assign range_sum  = SUM_W'(first_page) + SUM_W'(req.page_count) - SUM_W'(1);
  assign page_max   = SUM_W'({PAGE_BITS{1'b1}});
  assign range_end  = (range_sum > page_max) ? PAGE_BITS'(page_max) : PAGE_BITS'(range_sum);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (req.cmd)
            CMD_LOOKUP, CMD_STORE: state_next = S_ROOT;
            CMD_ENSURE: state_next = (req.page_count == '0) ? S_DONE : S_ENS_ROOT;
            default: state_next = S_DONE;
          endcase
        end
      end
      S_ROOT:       state_next = root_hit ? S_BCHK : S_DONE;
      S_BCHK:       state_next = (b_hit && !is_store) ? S_LWAIT : S_DONE;
      S_LWAIT:      state_next = S_DONE;
      S_ENS_ROOT: begin
        if (root_hit) begin
          state_next = S_ENS_BRD;
        end else if (bpool_empty) begin
          state_next = S_DONE;
        end else begin
          state_next = S_CLR_BRANCH;
        end
      end
      S_CLR_BRANCH: state_next = clr_branch_last ? S_ENS_BRD : S_CLR_BRANCH;
      S_ENS_BRD:    state_next = S_ENS_BCHK;
      S_ENS_BCHK: begin
        if (b_hit) begin
          state_next = S_ENS_NEXT;
        end else if (lpool_empty) begin
          state_next = S_DONE;
        end else begin
          state_next = S_CLR_LEAF;
        end
      end
      S_CLR_LEAF:   state_next = clr_leaf_last ? S_ENS_NEXT : S_CLR_LEAF;
      S_ENS_NEXT:   state_next = (grp == grp_last) ? S_DONE : S_ENS_ROOT;
      S_DONE:       state_next = (!rsp_vld || rsp.ready) ? S_IDLE : S_DONE;
      default:      state_next = S_IDLE;
    endcase
  end

  // Memory control, allocation strobes and result values
  always_comb begin
    b_we            = 1'b0;
    b_addr          = b_walk_addr;
    b_wdata         = '0;
    l_we            = 1'b0;
    l_addr          = LA_W'({b_node, lidx_q});
    l_wdata         = HANDLE_BITS'(handle_q);
    root_alloc      = 1'b0;
    leaf_alloc      = 1'b0;
    clr_step        = 1'b0;
    grp_step        = 1'b0;
    rsp_load        = 1'b0;
    res_set         = 1'b0;
    res_handle_next = '0;
    res_status_next = ST_OK;
    case (state)
      S_IDLE: begin
        // Unused command and empty ensure answer at once
        res_set = accept;
      end
      S_ROOT: begin
        if (!root_hit) begin
          res_set         = 1'b1;
          res_status_next = is_store ? ST_MISSING : ST_OK;
        end
      end
      S_BCHK: begin
        if (!b_hit) begin
          res_set         = 1'b1;
          res_status_next = is_store ? ST_MISSING : ST_OK;
        end else if (is_store) begin
          l_we    = 1'b1;
          res_set = 1'b1;
        end
      end
      S_LWAIT: begin
        res_set         = 1'b1;
        res_handle_next = SPAN_W'(l_rdata);
      end
      S_ENS_ROOT: begin
        if (!root_hit) begin
          if (bpool_empty) begin
            res_set         = 1'b1;
            res_status_next = ST_EXHAUSTED;
          end else begin
            root_alloc = 1'b1;
          end
        end
      end
      S_CLR_BRANCH: begin
        b_we     = 1'b1;
        b_addr   = BA_W'({root_nd, clr[BRANCH_BITS-1:0]});
        clr_step = 1'b1;
      end
      S_ENS_BCHK: begin
        if (!b_hit) begin
          if (lpool_empty) begin
            res_set         = 1'b1;
            res_status_next = ST_EXHAUSTED;
          end else begin
            b_we       = 1'b1;
            b_wdata    = {1'b1, LN_W'(lused)};
            leaf_alloc = 1'b1;
          end
        end
      end
      S_CLR_LEAF: begin
        l_we     = 1'b1;
        l_addr   = LA_W'({alloc_leaf, clr[LEAF_BITS-1:0]});
        l_wdata  = '0;
        clr_step = 1'b1;
      end
      S_ENS_NEXT: begin
        if (grp == grp_last) begin
          res_set = 1'b1;
        end else begin
          grp_step = 1'b1;
        end
      end
      S_DONE: begin
        rsp_load = !rsp_vld || rsp.ready;
      end
      default: begin
        res_set = 1'b0;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      bused   <= '0;
      lused   <= '0;
      rsp_vld <= 1'b0;
    end else begin
      state <= state_next;
      if (root_alloc) begin
        bused <= bused + BUSED_W'(1);
      end
      if (leaf_alloc) begin
        lused <= lused + LUSED_W'(1);
      end
      if (rsp_load) begin
        rsp_vld <= 1'b1;
      end else if (rsp.ready) begin
        rsp_vld <= 1'b0;
      end
    end
  end

  // Root entry valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ROOT_SIZE; i++) begin
        root_valid[i] <= 1'b0;
      end
    end else if (root_alloc) begin
      root_valid[r_idx] <= 1'b1;
    end
  end

  // Root entry node numbers
  always_ff @(posedge clk) begin
    if (root_alloc) begin
      root_node[r_idx] <= BN_W'(bused);
    end
  end

  // Transaction, walk and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q    <= req.cmd;
      lidx_q   <= first_page[LEAF_BITS-1:0];
      handle_q <= req.span_handle;
      grp      <= first_page[PAGE_BITS-1:LEAF_BITS];
      grp_last <= range_end[PAGE_BITS-1:LEAF_BITS];
    end else if (grp_step) begin
      grp <= grp + GROUP_BITS'(1);
    end
    if (root_alloc || leaf_alloc) begin
      clr <= '0;
    end else if (clr_step) begin
      clr <= clr + CLR_W'(1);
    end
    if (leaf_alloc) begin
      alloc_leaf <= LN_W'(lused);
    end
    if (res_set) begin
      res_handle <= res_handle_next;
      res_status <= res_status_next;
    end
    if (rsp_load) begin
      rsp_handle <= res_handle;
      rsp_status <= res_status;
    end
  end

endmodule

`default_nettype wire

FILE: src/tlpm_ram.sv
`default_nettype none

module tlpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    addr,
  input  wire logic [WIDTH-1:0] wdata,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write on request, register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

FILE: src/tlpm_checker.sv
`default_nettype none
`include "three_level_page_map_assert.svh"

module tlpm_checker import tlpm_pkg::*; (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                req_valid,
  input wire logic                req_ready,
  input wire logic                rsp_valid,
  input wire logic                rsp_ready,
  input wire logic [SPAN_W-1:0]   found_handle,
  input wire logic [STATUS_W-1:0] status
);

  logic [1:0] pending, pending_next;
  logic       req_fire, rsp_fire;

  assign req_fire = req_valid && req_ready;
  assign rsp_fire = rsp_valid && rsp_ready;

  // Count requests accepted and not yet answered
  always_comb begin
    pending_next = pending;
    if (req_fire && !rsp_fire) begin
      pending_next = pending + 2'd1;
    end else if (rsp_fire && !req_fire) begin
      pending_next = pending - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending_next;
    end
  end

  `TLPM_CHECK_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(found_handle) && $stable(status), "stalled response changed")
  `TLPM_CHECK_SAME(a_rsp_has_req, rsp_valid, pending != 2'd0, "response without an open request")
  `TLPM_CHECK_SAME(a_one_in_walk, req_fire, pending <= 2'd1, "request taken while walker busy")
  `TLPM_CHECK_SAME(a_err_no_handle, rsp_valid && status != ST_OK, found_handle == '0, "error response carries a handle")

endmodule

bind three_level_page_map tlpm_checker u_tlpm_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .found_handle (rsp.found_handle),
  .status       (rsp.status)
);

`default_nettype wire
